[design/i2c_slave_transfer_sequencer_core_macros.svh]
// Assertion macros for the I2C slave transfer sequencer.
// Included by the checker module; holds nothing but macro definitions.
`ifndef I2C_SLAVE_TRANSFER_SEQUENCER_CORE_MACROS_SVH
`define I2C_SLAVE_TRANSFER_SEQUENCER_CORE_MACROS_SVH

// Property checked only while reset is released.
`define I2CS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Property checked on every edge, reset included.
`define I2CS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/i2cs_pkg.sv]
// Shared types and codes for the I2C slave transfer sequencer.
// No dependencies; used by the step logic, the top level and the checker.
package i2cs_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ARM_TX = 2'd1,
        OP_ARM_RX = 2'd2,
        OP_EVENT  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        MODE_READY = 4'b0001,
        MODE_INIT  = 4'b0010,
        MODE_TX    = 4'b0100,
        MODE_RX    = 4'b1000
    } t_mode;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_LISTEN = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;
    localparam logic [1:0] ACT_STOP   = 2'd3;

    localparam logic [1:0] OUT_SUCCESS  = 2'd0;
    localparam logic [1:0] OUT_PROGRESS = 2'd1;
    localparam logic [1:0] OUT_FAILED   = 2'd2;

    // slave status codes, prescaler bits masked
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_SLA_W_ACK    = 8'h60;
    localparam logic [7:0] ST_ARB_SLA_W    = 8'h68;
    localparam logic [7:0] ST_GCALL_ACK    = 8'h70;
    localparam logic [7:0] ST_ARB_GCALL    = 8'h78;
    localparam logic [7:0] ST_DATA_ACK     = 8'h80;
    localparam logic [7:0] ST_DATA_NACK    = 8'h88;
    localparam logic [7:0] ST_GDATA_ACK    = 8'h90;
    localparam logic [7:0] ST_GDATA_NACK   = 8'h98;
    localparam logic [7:0] ST_STOP_RESTART = 8'hA0;
    localparam logic [7:0] ST_SLA_R_ACK    = 8'hA8;
    localparam logic [7:0] ST_ARB_SLA_R    = 8'hB0;
    localparam logic [7:0] ST_TX_ACK       = 8'hB8;
    localparam logic [7:0] ST_TX_NACK      = 8'hC0;
    localparam logic [7:0] ST_LAST_TX_ACK  = 8'hC8;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] outcome;
        logic [7:0] fail_code;
        logic [7:0] rx_counter;
    } t_ctrl;

    // first member is the top bits: bus_action lands in bits [1:0]
    typedef struct packed {
        logic       rejected;
        logic [7:0] fail_status;
        logic [1:0] outcome;
        logic       ready_res;
        logic [7:0] rx_count;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [1:0] bus_action;
    } t_result;

endpackage

[design/i2cs_step.sv]
// Per-transaction decision logic of the I2C slave transfer sequencer.
// Depends on i2cs_pkg; purely combinational, registered by the top level.
module i2cs_step
    import i2cs_pkg::*;
#(
    parameter int TX_DEPTH = 32,
    parameter int RX_LIMIT = 32,
    parameter int LW       = $clog2(TX_DEPTH + 1)
) (
    input  t_op           i_op,
    input  logic [7:0]    i_status,
    input  logic [7:0]    i_data_byte,
    input  logic [7:0]    i_length,
    input  logic [7:0]    i_store_data,
    input  t_ctrl         i_ctrl,
    input  logic [LW-1:0] i_tx_length,
    input  logic [LW-1:0] i_tx_position,
    output t_ctrl         o_ctrl,
    output logic [LW-1:0] o_tx_length,
    output logic [LW-1:0] o_tx_position,
    output t_result       o_result
);

    logic       too_long;
    logic [1:0] action;
    logic       txv;
    logic [7:0] txb;
    logic       rxv;
    logic [7:0] rxb;
    logic       rej;

    always_comb begin
        if (i_op == OP_ARM_TX) begin
            too_long = {1'b0, i_length} > 9'(TX_DEPTH);
        end else begin
            too_long = i_length > 8'(RX_LIMIT);
        end
    end

    always_comb begin
        o_ctrl        = i_ctrl;
        o_tx_length   = i_tx_length;
        o_tx_position = i_tx_position;
        action        = ACT_NONE;
        txv           = 1'b0;
        txb           = 8'h00;
        rxv           = 1'b0;
        rxb           = 8'h00;
        rej           = 1'b0;
        case (i_op)
            OP_LOAD: begin
                // store write happens in the top level
            end
            OP_ARM_TX, OP_ARM_RX: begin
                if (i_ctrl.mode != MODE_READY || too_long) begin
                    rej = 1'b1;
                end else begin
                    o_ctrl.mode = MODE_INIT;
                    if (i_op == OP_ARM_TX) begin
                        o_tx_length   = LW'(i_length);
                        o_tx_position = '0;
                    end else begin
                        o_ctrl.rx_counter = 8'h00;
                    end
                    action = ACT_ACK;
                end
            end
            OP_EVENT: begin
                case (i_status)
                    ST_SLA_R_ACK, ST_TX_ACK: begin
                        if (i_status == ST_SLA_R_ACK) begin
                            o_ctrl.mode = MODE_TX;
                        end
                        o_ctrl.outcome = OUT_SUCCESS;
                        txv = 1'b1;
                        if (i_tx_position < i_tx_length &&
                            i_tx_position < LW'(TX_DEPTH)) begin
                            txb           = i_store_data;
                            o_tx_position = i_tx_position + LW'(1);
                        end else begin
                            txb = 8'hFF;
                        end
                        action = ACT_ACK;
                    end
                    ST_TX_NACK: begin
                        if (i_tx_position >= i_tx_length) begin
                            o_ctrl.outcome = OUT_SUCCESS;
                        end else begin
                            o_ctrl.outcome   = OUT_FAILED;
                            o_ctrl.fail_code = i_status;
                        end
                        o_ctrl.mode = MODE_READY;
                        action      = ACT_LISTEN;
                    end
                    ST_SLA_W_ACK, ST_GCALL_ACK: begin
                        o_ctrl.mode = MODE_RX;
                        action      = ACT_ACK;
                    end
                    ST_DATA_ACK, ST_GDATA_ACK: begin
                        if (i_ctrl.rx_counter != 8'hFF) begin
                            o_ctrl.rx_counter = i_ctrl.rx_counter + 8'd1;
                        end
                        rxv            = 1'b1;
                        rxb            = i_data_byte;
                        o_ctrl.outcome = OUT_PROGRESS;
                        action         = ACT_ACK;
                    end
                    ST_STOP_RESTART: begin
                        o_ctrl.mode = MODE_READY;
                        action      = ACT_LISTEN;
                    end
                    ST_LAST_TX_ACK, ST_DATA_NACK, ST_GDATA_NACK, ST_BUS_ERROR: begin
                        o_ctrl.outcome   = OUT_FAILED;
                        o_ctrl.fail_code = i_status;
                        o_ctrl.mode      = MODE_READY;
                        action           = ACT_STOP;
                    end
                    ST_ARB_SLA_W, ST_ARB_GCALL, ST_ARB_SLA_R: begin
                        o_ctrl.outcome   = OUT_FAILED;
                        o_ctrl.fail_code = i_status;
                        o_ctrl.mode      = MODE_READY;
                        action           = ACT_LISTEN;
                    end
                    default: begin
                        // no-info and unknown codes leave everything alone
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.bus_action  = action;
        o_result.tx_valid    = txv;
        o_result.tx_byte     = txb;
        o_result.rx_valid    = rxv;
        o_result.rx_byte     = rxb;
        o_result.rx_count    = o_ctrl.rx_counter;
        o_result.ready_res   = (o_ctrl.mode == MODE_READY);
        o_result.outcome     = o_ctrl.outcome;
        o_result.fail_status = o_ctrl.fail_code;
        o_result.rejected    = rej;
    end

endmodule

[design/i2c_slave_transfer_sequencer_core.sv]
// Top level of the I2C slave transfer sequencer: stream ports, input and
// result registers, transmit byte store. Depends on i2cs_pkg and i2cs_step.
//
//  channel | dir | tdata / tuser                                  | per transaction
//  s_axis  | in  | op in tuser, status/data_byte/slot/length      | one command or bus event
//  m_axis  | out | bus_action..rejected, 40 bits                  | one result per command or event
//
// An accepted transaction is registered, decided by the step logic and its result
// registered in turn; one transaction per cycle while m_axis does not stall.
// The rate is set by the single step of decision logic between the two registers.
// A stall on m_axis holds the result; s_axis keeps accepting until the input
// register is also full. Reset is synchronous, active low, and returns the
// block to ready with success, empty pipeline; the byte store is not cleared.
module i2c_slave_transfer_sequencer_core
    import i2cs_pkg::*;
#(
    parameter int TX_DEPTH = 32,
    parameter int RX_LIMIT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status, [15:8] data_byte, [20:16] slot, [28:21] length, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] bus_action, [2] tx_valid, [10:3] tx_byte, [11] rx_valid,
    // [19:12] rx_byte, [27:20] rx_count, [28] ready_res, [30:29] outcome,
    // [38:31] fail_status, [39] rejected
    output logic [39:0] m_axis_tdata
);

    localparam int LW = $clog2(TX_DEPTH + 1);
    // slot is five bits, so at most 32 entries can ever be written
    localparam int SD = (TX_DEPTH < 32) ? TX_DEPTH : 32;
    localparam int IW = (SD > 1) ? $clog2(SD) : 1;

    logic          r_in_valid;
    t_op           r_op;
    logic [7:0]    r_status;
    logic [7:0]    r_data_byte;
    logic [4:0]    r_slot;
    logic [7:0]    r_length;

    t_ctrl         r_ctrl;
    t_ctrl         n_ctrl;
    logic [LW-1:0] r_tx_length;
    logic [LW-1:0] n_tx_length;
    logic [LW-1:0] r_tx_position;
    logic [LW-1:0] n_tx_position;

    logic [7:0]    r_store [SD];
    logic [7:0]    r_store_rd;
    logic [LW-1:0] rd_pos;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic          wr_en;

    logic          r_out_valid;
    t_result       r_out;
    t_result       n_out;

    logic          s_acc;
    logic          adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // store read is registered, at the transmit position in force next cycle
    assign rd_pos = adv ? n_tx_position : r_tx_position;
    assign rd_idx = (rd_pos < LW'(SD)) ? rd_pos[IW-1:0] : '0;
    assign wr_idx = ({4'd0, r_slot} < 9'(SD)) ? r_slot[IW-1:0] : '0;
    assign wr_en  = adv && (r_op == OP_LOAD) && ({4'd0, r_slot} < 9'(TX_DEPTH));

    i2cs_step #(
        .TX_DEPTH (TX_DEPTH),
        .RX_LIMIT (RX_LIMIT),
        .LW       (LW)
    ) u_step (
        .i_op          (r_op),
        .i_status      (r_status),
        .i_data_byte   (r_data_byte),
        .i_length      (r_length),
        .i_store_data  (r_store_rd),
        .i_ctrl        (r_ctrl),
        .i_tx_length   (r_tx_length),
        .i_tx_position (r_tx_position),
        .o_ctrl        (n_ctrl),
        .o_tx_length   (n_tx_length),
        .o_tx_position (n_tx_position),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ctrl.mode       <= MODE_READY;
            r_ctrl.outcome    <= OUT_SUCCESS;
            r_ctrl.fail_code  <= 8'h00;
            r_ctrl.rx_counter <= 8'h00;
            r_tx_length   <= '0;
            r_tx_position <= '0;
        end else begin
            if (s_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_ctrl        <= n_ctrl;
                r_tx_length   <= n_tx_length;
                r_tx_position <= n_tx_position;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op        <= t_op'(s_axis_tuser);
            r_status    <= s_axis_tdata[7:0];
            r_data_byte <= s_axis_tdata[15:8];
            r_slot      <= s_axis_tdata[20:16];
            r_length    <= s_axis_tdata[28:21];
        end
        if (adv) begin
            r_out <= n_out;
        end
        if (wr_en) begin
            r_store[wr_idx] <= r_data_byte;
        end
        // a load to the entry being fetched passes its byte straight through
        if (wr_en && wr_idx == rd_idx) begin
            r_store_rd <= r_data_byte;
        end else begin
            r_store_rd <= r_store[rd_idx];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

[design/i2cs_checker.sv]
// Port-level checks for the I2C slave transfer sequencer, bound to the top.
// Depends on i2cs_pkg and i2c_slave_transfer_sequencer_core_macros.svh.
`include "i2c_slave_transfer_sequencer_core_macros.svh"

module i2cs_checker
    import i2cs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata
);

    t_result res;
    logic    stalled;
    logic    quiet_ok;
    logic    flags_ok;
    logic    count_ok;

    assign res      = i_m_tdata;
    assign stalled  = i_m_tvalid && !i_m_tready;
    assign quiet_ok = res.bus_action == ACT_NONE && !res.tx_valid && !res.rx_valid;
    assign flags_ok = (res.tx_valid || res.tx_byte == 8'h00) &&
                      (res.rx_valid || res.rx_byte == 8'h00) &&
                      !(res.tx_valid && res.rx_valid);
    assign count_ok = res.rx_count != 8'h00 && res.outcome == OUT_PROGRESS;

    // stalled result holds
    `I2CS_ASSERT(a_out_hold, i_clk, i_rst_n, stalled |=> i_m_tvalid && $stable(i_m_tdata), "result moved")

    // a refused arm takes no bus action and moves no data
    `I2CS_ASSERT(a_reject_quiet, i_clk, i_rst_n, i_m_tvalid && res.rejected |-> quiet_ok, "arm side effects")

    // data bytes are zero unless flagged, and never both directions at once
    `I2CS_ASSERT(a_byte_flags, i_clk, i_rst_n, i_m_tvalid |-> flags_ok, "byte fields inconsistent with flags")

    // a received byte always leaves a nonzero count and a progress outcome
    `I2CS_ASSERT(a_rx_count, i_clk, i_rst_n, i_m_tvalid && res.rx_valid |-> count_ok, "byte without count")

    // pipeline empty right after reset
    `I2CS_ASSERT_ALWAYS(a_reset_empty, i_clk, i_rst_n && !$past(i_rst_n) |-> !i_m_tvalid, "valid after reset")

endmodule

bind i2c_slave_transfer_sequencer_core i2cs_checker u_i2cs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
